// File: hw/rtl/tpc_pkg.sv
// shared types and codes of the threshold promote cache list
package tpc_pkg;

   // request and result codes
   typedef logic [1:0] cmd_type;
   typedef logic [1:0] status_type;

   localparam cmd_type CMD_ACCESS = 2'd0;
   localparam cmd_type CMD_REMOVE = 2'd1;
   localparam cmd_type CMD_QUERY  = 2'd2;
   localparam cmd_type CMD_FLUSH  = 2'd3;

   localparam status_type ST_FOUND  = 2'd0;
   localparam status_type ST_ABSENT = 2'd1;
   localparam status_type ST_EMPTY  = 2'd2;

   // register file
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam int CAP_W      = 5;
   localparam int THR_W      = 16;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_CAPACITY  = 1'd0;
   localparam csr_idx_type CSR_THRESHOLD = 1'd1;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // what each cell does in the apply cycle
   typedef logic [1:0] cell_mode_type;

   localparam cell_mode_type MODE_HOLD  = 2'd0;
   localparam cell_mode_type MODE_FRONT = 2'd1;
   localparam cell_mode_type MODE_BUMP  = 2'd2;
   localparam cell_mode_type MODE_PULL  = 2'd3;

   typedef struct packed {
      logic          fire;
      cell_mode_type mode;
   } cell_ctl_type;

endpackage

// File: hw/rtl/tpc_cell.sv
// one position of the cache list: key, count, compare and neighbor shift
module tpc_cell #(
   parameter int INDEX   = 0,
   parameter int KEY_W   = 32,
   parameter int COUNT_W = 16,
   parameter int IDX_W   = 4,
   parameter int OCC_W   = 5
) (
   input  logic                  clock,
   input  tpc_pkg::cell_ctl_type ctl,
   input  logic [IDX_W-1:0]      pos,
   input  logic [COUNT_W-1:0]    new_count,
   input  logic [KEY_W-1:0]      prev_key,
   input  logic [COUNT_W-1:0]    prev_count,
   input  logic [KEY_W-1:0]      next_key,
   input  logic [COUNT_W-1:0]    next_count,
   input  logic [KEY_W-1:0]      cmp_key,
   input  logic [OCC_W-1:0]      occ,
   output logic [KEY_W-1:0]      key_q,
   output logic [COUNT_W-1:0]    count_q,
   output logic                  hit,
   output logic [COUNT_W-1:0]    hit_count,
   output logic [KEY_W-1:0]      tail_key
);
   import tpc_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(INDEX);
   localparam logic [OCC_W-1:0] MY_OCC  = OCC_W'(INDEX);
   localparam logic [OCC_W-1:0] MY_TAIL = OCC_W'(INDEX + 1);

   logic [KEY_W-1:0]   key_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               live;

   assign live      = MY_OCC < occ;
   assign hit       = live && (key_ff == cmp_key);
   assign hit_count = hit ? count_ff : '0;
   assign tail_key  = (occ == MY_TAIL) ? key_ff : '0;
   assign key_q     = key_ff;
   assign count_q   = count_ff;

   always_ff @(posedge clock) begin
      if (ctl.fire) begin
         unique case (ctl.mode)
            MODE_HOLD: begin
            end
            MODE_FRONT: begin
               // everything at or below the bound slides one place back
               if (MY_IDX <= pos) begin
                  key_ff   <= prev_key;
                  count_ff <= prev_count;
               end
            end
            MODE_BUMP: begin
               if (MY_IDX == pos) begin
                  count_ff <= new_count;
               end
            end
            MODE_PULL: begin
               // close the gap left by a removed entry
               if (MY_IDX >= pos) begin
                  key_ff   <= next_key;
                  count_ff <= next_count;
               end
            end
         endcase
      end
   end

endmodule

// File: hw/rtl/threshold_promote_cache_list.sv
// top level of the threshold promote cache list
//
//   channel  | handshake             | word
//   req      | req_valid / req_stall | req_cmd, req_key
//   rsp      | rsp_valid / rsp_stall | rsp_status, rsp_count, rsp_evicted,
//            |                       | rsp_evicted_key, rsp_occupancy
//   csr      | csr_valid / csr_ready | csr_index, csr_wdata
//
// every request passes a compare phase, which checks the key against all cells in parallel,
// then a shift phase on the cell chain; the next request is taken in the shift cycle.
// a response sits in an output register; if it is stalled the shift cycle waits.
// reset (synchronous) empties the list and sets capacity 16, threshold 0;
// cell contents are not reset. csr writes are always taken (ready held high).
module threshold_promote_cache_list #(
   parameter int DEPTH   = 16,
   parameter int KEY_W   = 32,
   parameter int COUNT_W = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  tpc_pkg::cmd_type                 req_cmd,
   input  logic [KEY_W-1:0]                 req_key,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output tpc_pkg::status_type              rsp_status,
   output logic [COUNT_W-1:0]               rsp_count,
   output logic                             rsp_evicted,
   output logic [KEY_W-1:0]                 rsp_evicted_key,
   output logic [$clog2(DEPTH+1)-1:0]       rsp_occupancy,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  tpc_pkg::csr_idx_type             csr_index,
   input  logic [tpc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tpc_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam int CW    = ((OCC_W > CAP_W) ? OCC_W : CAP_W) + 1;
   localparam int TW    = (COUNT_W > THR_W) ? COUNT_W : THR_W;

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_CMP   = 2'd1;
   localparam logic [1:0] PH_APPLY = 2'd2;

   // configuration
   logic [CAP_W-1:0] capacity_ff;
   logic [THR_W-1:0] threshold_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         threshold_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CAPACITY:  capacity_ff  <= csr_wdata[CAP_W-1:0];
            CSR_THRESHOLD: threshold_ff <= csr_wdata[THR_W-1:0];
         endcase
      end
   end

   // sequencing
   logic [1:0]       phase_ff, phase_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free, apply_fire, req_accept;
   logic [OCC_W-1:0] occ_ff, occ_in;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign apply_fire = (phase_ff == PH_APPLY) && out_free;
   assign req_stall  = !((phase_ff == PH_IDLE) || apply_fire);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      unique case (phase_ff)
         PH_IDLE:  phase_in = req_accept ? PH_CMP : PH_IDLE;
         PH_CMP:   phase_in = PH_APPLY;
         PH_APPLY: begin
            if (apply_fire) begin
               phase_in = req_accept ? PH_CMP : PH_IDLE;
            end else begin
               phase_in = PH_APPLY;
            end
         end
         default:  phase_in = PH_IDLE;
      endcase
   end

   assign rsp_valid_in = apply_fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
         occ_ff       <= '0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         if (apply_fire) begin
            occ_ff <= occ_in;
         end
      end
   end

   // request word
   cmd_type          cmd_ff;
   logic [KEY_W-1:0] key_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff <= req_cmd;
         key_ff <= req_key;
      end
   end

   // cell chain
   cell_ctl_type       ctl;
   cell_mode_type      mode_in;
   logic [IDX_W-1:0]   bound_in;
   logic [COUNT_W-1:0] new_count_in;

   logic [KEY_W-1:0]   cell_key   [DEPTH];
   logic [COUNT_W-1:0] cell_count [DEPTH];
   logic [COUNT_W-1:0] cell_hcnt  [DEPTH];
   logic [KEY_W-1:0]   cell_tail  [DEPTH];
   logic [DEPTH-1:0]   match_vec;

   assign ctl.fire = apply_fire;
   assign ctl.mode = mode_in;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [KEY_W-1:0]   prev_key, next_key;
      logic [COUNT_W-1:0] prev_count, next_count;

      if (g == 0) begin : g_front
         // the new front entry comes in ahead of cell zero
         assign prev_key   = key_ff;
         assign prev_count = new_count_in;
      end else begin : g_mid
         assign prev_key   = cell_key[g-1];
         assign prev_count = cell_count[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign next_key   = cell_key[g];
         assign next_count = cell_count[g];
      end else begin : g_inner
         assign next_key   = cell_key[g+1];
         assign next_count = cell_count[g+1];
      end

      tpc_cell #(
         .INDEX   (g),
         .KEY_W   (KEY_W),
         .COUNT_W (COUNT_W),
         .IDX_W   (IDX_W),
         .OCC_W   (OCC_W)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .pos        (bound_in),
         .new_count  (new_count_in),
         .prev_key   (prev_key),
         .prev_count (prev_count),
         .next_key   (next_key),
         .next_count (next_count),
         .cmp_key    (key_ff),
         .occ        (occ_ff),
         .key_q      (cell_key[g]),
         .count_q    (cell_count[g]),
         .hit        (match_vec[g]),
         .hit_count  (cell_hcnt[g]),
         .tail_key   (cell_tail[g])
      );
   end

   // compare cycle: keys are unique, so at most one cell hits and an or merges
   logic [IDX_W-1:0]   pos_sel;
   logic [COUNT_W-1:0] count_sel;
   logic [KEY_W-1:0]   tail_sel;

   always_comb begin
      pos_sel   = '0;
      count_sel = '0;
      tail_sel  = '0;
      for (int i = 0; i < DEPTH; i++) begin
         pos_sel   = pos_sel | (match_vec[i] ? IDX_W'(i) : '0);
         count_sel = count_sel | cell_hcnt[i];
         tail_sel  = tail_sel | cell_tail[i];
      end
   end

   logic               found_ff;
   logic [IDX_W-1:0]   pos_ff;
   logic [COUNT_W-1:0] hit_count_ff;
   logic [KEY_W-1:0]   tail_key_ff;

   always_ff @(posedge clock) begin
      if (phase_ff == PH_CMP) begin
         found_ff     <= |match_vec;
         pos_ff       <= pos_sel;
         hit_count_ff <= count_sel;
         tail_key_ff  <= tail_sel;
      end
   end

   // apply cycle
   logic [COUNT_W-1:0] count_inc;
   logic               promote;
   logic [CW-1:0]      cap_eff, occ_ext;
   logic               need_evict;
   status_type         status_in;
   logic [COUNT_W-1:0] count_in;
   logic               evicted_in;
   logic [KEY_W-1:0]   evicted_key_in;

   assign count_inc  = (hit_count_ff == '1) ? hit_count_ff : hit_count_ff + 1'b1;
   assign promote    = (TW'(count_inc) > TW'(threshold_ff)) && (pos_ff != '0);
   assign occ_ext    = CW'(occ_ff);
   assign cap_eff    = (CW'(capacity_ff) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(capacity_ff);
   assign need_evict = (occ_ext + CW'(1)) > cap_eff;

   always_comb begin
      mode_in        = MODE_HOLD;
      bound_in       = pos_ff;
      new_count_in   = count_inc;
      status_in      = ST_FOUND;
      count_in       = '0;
      evicted_in     = 1'b0;
      evicted_key_in = '0;
      occ_in         = occ_ff;
      unique case (cmd_ff)
         CMD_FLUSH: begin
            occ_in = '0;
         end
         CMD_ACCESS: begin
            if (found_ff) begin
               count_in = count_inc;
               mode_in  = promote ? MODE_FRONT : MODE_BUMP;
            end else begin
               status_in    = ST_ABSENT;
               new_count_in = COUNT_W'(1);
               bound_in     = '1;
               if (need_evict && (occ_ff == '0)) begin
                  // nothing room for: the new key itself is dropped
                  evicted_in     = 1'b1;
                  evicted_key_in = key_ff;
               end else if (need_evict) begin
                  evicted_in     = 1'b1;
                  evicted_key_in = tail_key_ff;
                  mode_in        = MODE_FRONT;
                  count_in       = COUNT_W'(1);
               end else begin
                  mode_in  = MODE_FRONT;
                  count_in = COUNT_W'(1);
                  occ_in   = occ_ff + 1'b1;
               end
            end
         end
         CMD_REMOVE, CMD_QUERY: begin
            if (occ_ff == '0) begin
               status_in = ST_EMPTY;
            end else if (!found_ff) begin
               status_in = ST_ABSENT;
            end else if (cmd_ff == CMD_REMOVE) begin
               mode_in = MODE_PULL;
               occ_in  = occ_ff - 1'b1;
            end else begin
               count_in = hit_count_ff;
            end
         end
      endcase
   end

   // response register
   status_type         status_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               evicted_ff;
   logic [KEY_W-1:0]   evicted_key_ff;
   logic [OCC_W-1:0]   rsp_occ_ff;

   always_ff @(posedge clock) begin
      if (apply_fire) begin
         status_ff      <= status_in;
         count_ff       <= count_in;
         evicted_ff     <= evicted_in;
         evicted_key_ff <= evicted_key_in;
         rsp_occ_ff     <= occ_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_count       = count_ff;
   assign rsp_evicted     = evicted_ff;
   assign rsp_evicted_key = evicted_key_ff;
   assign rsp_occupancy   = rsp_occ_ff;

   // checks
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(DEPTH))
      else $error("occupancy above depth");

   a_unique_hit: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CMP) |-> $onehot0(match_vec))
      else $error("key present in more than one cell");

   a_accept_to_cmp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (phase_ff == PH_CMP))
      else $error("accepted word did not enter compare");

   a_rsp_from_apply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(phase_ff == PH_APPLY))
      else $error("response without apply cycle");

endmodule

// File: bench/threshold_promote_cache_list_tb.sv
// self-checking testbench of the threshold promote cache list: directed, random and soak traffic
module threshold_promote_cache_list_tb;
   import tpc_pkg::*;

   localparam int SLOTS       = 16;
   localparam int RUN_LIMIT   = 1000000;
   localparam int HOLD_CYCLES = 400;
   localparam int POOL_SIZE   = 20;
   localparam int SOAK_HITS   = 80;

   typedef struct {
      cmd_type     cmd;
      logic [31:0] key;
   } cache_req_t;

   typedef struct {
      status_type  status;
      logic [15:0] count;
      logic        evicted;
      logic [31:0] ev_key;
      logic [4:0]  occupancy;
   } cache_reply_t;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   cmd_type          req_cmd = CMD_ACCESS;
   logic [31:0]      req_key = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   status_type       rsp_status;
   logic [15:0]      rsp_count;
   logic             rsp_evicted;
   logic [31:0]      rsp_evicted_key;
   logic [4:0]       rsp_occupancy;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   csr_idx_type      csr_index = CSR_CAPACITY;
   logic [15:0]      csr_wdata = '0;

   threshold_promote_cache_list u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_count       (rsp_count),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key),
      .rsp_occupancy   (rsp_occupancy),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #4 clock = ~clock;

   // mirror of the cell chain and its registers
   logic [31:0] mirror_keys [SLOTS];
   logic [15:0] mirror_counts [SLOTS];
   int          mirror_fill = 0;
   logic [4:0]  cap_reg = CAP_RESET;
   logic [15:0] thr_reg = '0;

   cache_req_t   req_backlog [$];
   cache_reply_t replies_due [$];
   logic [31:0]  key_pool [POOL_SIZE];

   int  cycle_count = 0;
   int  requests_sent = 0;
   int  answers_checked = 0;
   int  mismatches = 0;
   int  settings_used = 0;
   int  evictions = 0;
   int  promotions = 0;
   int  saturations = 0;
   bit  req_taken = 1'b0;
   bit  steady = 1'b0;
   bit  hold_armed = 1'b0;
   int  hold_mark = 0;
   int  hold_left = 0;

   function automatic bit take_break();
      return !steady && ($urandom_range(0, 99) < 6);
   endfunction

   // put a key at the front with the given count, pushing the rest back
   function automatic void shift_in(logic [31:0] key, logic [15:0] cnt);
      for (int i = mirror_fill; i > 0; i--) begin
         mirror_keys[i]   = mirror_keys[i-1];
         mirror_counts[i] = mirror_counts[i-1];
      end
      mirror_keys[0]   = key;
      mirror_counts[0] = cnt;
      mirror_fill++;
   endfunction

   // updates the mirror for one request and returns the reply it must produce
   function automatic cache_reply_t next_reply(cmd_type cmd, logic [31:0] key);
      cache_reply_t r;
      int           pos;
      int           lim;
      logic [15:0]  c;
      r   = '{status: ST_FOUND, count: '0, evicted: 1'b0, ev_key: '0, occupancy: '0};
      lim = (cap_reg > SLOTS) ? SLOTS : int'(cap_reg);
      pos = -1;
      for (int i = 0; i < mirror_fill; i++)
         if (pos < 0 && mirror_keys[i] == key) pos = i;
      case (cmd)
         CMD_FLUSH: mirror_fill = 0;
         CMD_ACCESS: begin
            if (pos >= 0) begin
               c = mirror_counts[pos];
               if (c != 16'hFFFF) c++;
               else saturations++;
               mirror_counts[pos] = c;
               if (c > thr_reg && pos > 0) begin
                  for (int i = pos; i > 0; i--) begin
                     mirror_keys[i]   = mirror_keys[i-1];
                     mirror_counts[i] = mirror_counts[i-1];
                  end
                  mirror_keys[0]   = key;
                  mirror_counts[0] = c;
                  promotions++;
               end
               r.count = c;
            end else begin
               r.status = ST_ABSENT;
               if (mirror_fill + 1 > lim) begin
                  r.evicted = 1'b1;
                  evictions++;
                  // with nothing to drop, the new key itself falls out
                  if (mirror_fill == 0) begin
                     r.ev_key = key;
                  end else begin
                     r.ev_key = mirror_keys[mirror_fill-1];
                     mirror_fill--;
                     shift_in(key, 16'd1);
                     r.count = 16'd1;
                  end
               end else begin
                  shift_in(key, 16'd1);
                  r.count = 16'd1;
               end
            end
         end
         default: begin
            if (mirror_fill == 0) begin
               r.status = ST_EMPTY;
            end else if (pos < 0) begin
               r.status = ST_ABSENT;
            end else if (cmd == CMD_REMOVE) begin
               for (int i = pos; i + 1 < mirror_fill; i++) begin
                  mirror_keys[i]   = mirror_keys[i+1];
                  mirror_counts[i] = mirror_counts[i+1];
               end
               mirror_fill--;
            end else begin
               r.count = mirror_counts[pos];
            end
         end
      endcase
      r.occupancy = mirror_fill[4:0];
      return r;
   endfunction

   task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= 100)
         $display("mismatch on reply %0d (cycle %0d): %s got %h, want %h",
                  answers_checked, cycle_count, field, got, want);
   endtask

   // request driver: accept at the rising edge, present the next word at the falling edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         replies_due.push_back(next_reply(req_cmd, req_key));
         void'(req_backlog.pop_front());
         req_taken = 1'b1;
         requests_sent++;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_backlog.size() > 0 && !take_break()) begin
            req_valid <= 1'b1;
            req_cmd   <= req_backlog[0].cmd;
            req_key   <= req_backlog[0].key;
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_taken = 1'b0;
   end

   // reply side back-pressure, with one long hold-off when armed
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_armed && answers_checked >= hold_mark) begin
         hold_armed = 1'b0;
         hold_left  = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= take_break();
      end
   end

   always @(posedge clock) begin : reply_check
      cache_reply_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         answers_checked++;
         if (replies_due.size() == 0) begin
            flag_mismatch("reply with nothing outstanding", '0, '0);
         end else begin
            want = replies_due.pop_front();
            if (rsp_status !== want.status)
               flag_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (rsp_count !== want.count)
               flag_mismatch("count", 32'(rsp_count), 32'(want.count));
            if (rsp_evicted !== want.evicted)
               flag_mismatch("evicted", 32'(rsp_evicted), 32'(want.evicted));
            if (rsp_evicted_key !== want.ev_key)
               flag_mismatch("evicted_key", rsp_evicted_key, want.ev_key);
            if (rsp_occupancy !== want.occupancy)
               flag_mismatch("occupancy", 32'(rsp_occupancy), 32'(want.occupancy));
         end
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= RUN_LIMIT);
      $display("timeout after %0d cycles, %0d requests queued, %0d replies outstanding",
               cycle_count, req_backlog.size(), replies_due.size());
      $display("Test completed with failures");
      $finish;
   end

   task automatic queue_req(cmd_type cmd, logic [31:0] key);
      req_backlog.push_back('{cmd: cmd, key: key});
   endtask

   // wait until every queued word is taken and answered, then let the chain settle
   task automatic settle();
      while (req_backlog.size() != 0 || replies_due.size() != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_CAPACITY) cap_reg = val[4:0];
      else thr_reg = val;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(logic [4:0] cap, logic [15:0] thr, int n, bit squeeze);
      int          r;
      cmd_type     cmd;
      logic [31:0] key;
      write_reg(CSR_CAPACITY, 16'(cap));
      write_reg(CSR_THRESHOLD, thr);
      settings_used++;
      if (squeeze) begin
         hold_mark  = answers_checked + 60;
         hold_armed = 1'b1;
      end
      // mostly pool keys so hits, promotions and evictions happen; flush kept rare
      for (int i = 0; i < n; i++) begin
         r   = $urandom_range(0, 99);
         cmd = (r < 62) ? CMD_ACCESS : (r < 76) ? CMD_REMOVE : (r < 97) ? CMD_QUERY : CMD_FLUSH;
         key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, POOL_SIZE-1)];
         queue_req(cmd, key);
      end
      settle();
   endtask

   initial begin
      logic [31:0] soak_key;
      logic [31:0] other_key;
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: empty cache, insert, hit with promotion, remove, flush
      settings_used++;
      queue_req(CMD_QUERY, 32'd5);
      queue_req(CMD_REMOVE, 32'd5);
      queue_req(CMD_ACCESS, 32'h0000_0000);
      queue_req(CMD_ACCESS, 32'hFFFF_FFFF);
      queue_req(CMD_ACCESS, 32'h0000_0000);
      queue_req(CMD_QUERY, 32'hFFFF_FFFF);
      queue_req(CMD_QUERY, 32'd123);
      queue_req(CMD_REMOVE, 32'd123);
      queue_req(CMD_REMOVE, 32'h0000_0000);
      queue_req(CMD_FLUSH, 32'hA5A5_5A5A);
      queue_req(CMD_ACCESS, 32'd7);
      settle();

      // single slot: the only entry gets pushed out
      write_reg(CSR_CAPACITY, 16'd1);
      settings_used++;
      queue_req(CMD_ACCESS, 32'd8);
      queue_req(CMD_ACCESS, 32'd8);
      settle();

      // zero capacity, first with an entry present, then on an empty cache
      write_reg(CSR_CAPACITY, 16'd0);
      settings_used++;
      queue_req(CMD_ACCESS, 32'd9);
      queue_req(CMD_FLUSH, 32'd0);
      queue_req(CMD_ACCESS, 32'd10);
      queue_req(CMD_QUERY, 32'd10);
      settle();

      // random traffic; state carries across so a lowered capacity meets a full cache
      run_phase(5'd16, 16'd0, 200, 1'b0);
      run_phase(5'd5, 16'd2, 250, 1'b0);
      run_phase(5'd31, 16'd1, 250, 1'b1);
      run_phase(5'd0, 16'd0, 150, 1'b0);
      run_phase(5'd1, 16'hFFFF, 150, 1'b0);
      run_phase(5'($urandom_range(2, 15)), 16'($urandom_range(0, 7)), 300, 1'b0);
      run_phase(5'd16, 16'($urandom_range(0, 65535)), 150, 1'b0);

      // hammer one key behind another with no idling on either side
      soak_key  = $urandom;
      other_key = ~soak_key;
      write_reg(CSR_CAPACITY, 16'd16);
      write_reg(CSR_THRESHOLD, 16'hFFFF);
      settings_used++;
      steady = 1'b1;
      queue_req(CMD_FLUSH, 32'd0);
      queue_req(CMD_ACCESS, soak_key);
      queue_req(CMD_ACCESS, other_key);
      for (int i = 0; i < SOAK_HITS; i++) queue_req(CMD_ACCESS, soak_key);
      queue_req(CMD_QUERY, soak_key);
      settle();
      steady = 1'b0;

      // a count above a lowered threshold moves the key to the front
      write_reg(CSR_THRESHOLD, 16'd50);
      settings_used++;
      queue_req(CMD_ACCESS, soak_key);
      queue_req(CMD_QUERY, other_key);
      settle();

      repeat (8) @(posedge clock);
      $display("ran %0d requests under %0d register settings, %0d replies checked",
               requests_sent, settings_used, answers_checked);
      $display("saw %0d evictions, %0d promotions, %0d hits at the count ceiling",
               evictions, promotions, saturations);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: threshold_promote_cache_list.f
hw/rtl/tpc_pkg.sv
hw/rtl/tpc_cell.sv
hw/rtl/threshold_promote_cache_list.sv
bench/threshold_promote_cache_list_tb.sv
